>>> design/macroblock_ycbcr_to_rgb_writer_top_assert.svh
// Assertion macros for the macroblock colour writer.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef MACROBLOCK_YCBCR_TO_RGB_WRITER_TOP_ASSERT_SVH
`define MACROBLOCK_YCBCR_TO_RGB_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, muted in reset.
`define MBRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, muted in reset.
`define MBRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mbrw_pkg.sv
package mbrw_pkg;

  // Field widths
  localparam int ADDR_W     = 16;   // macroblock address
  localparam int POS_W      = 4;    // column / row inside a macroblock
  localparam int PIX_W      = 8;    // one sample
  localparam int FW_W       = 12;   // frame width / height
  localparam int PR_W       = 9;    // macroblocks per row
  localparam int MBC_W      = 16;   // macroblock count
  localparam int CFG_DATA_W = 16;
  localparam int OUT_ADDR_W = 24;
  localparam int RGB_W      = 24;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 48;

  localparam int MB_SIZE    = 16;
  localparam logic [POS_W-1:0] MB_LAST_POS = POS_W'(MB_SIZE - 1);

  localparam int COEF_FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd720;
  localparam logic [FW_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [PR_W-1:0]  MBS_PER_ROW_RST  = 9'd45;
  localparam logic [MBC_W-1:0] MB_COUNT_RST     = 16'd1350;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MBS_PER_ROW  = 2'd2,
    CFG_MB_COUNT     = 2'd3
  } cfg_idx_t;

  // Per-pixel attributes carried alongside the address division
  typedef struct packed {
    logic             intra;
    logic             done;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [RGB_W-1:0] rgb;
  } mbrw_side_t;

endpackage

>>> design/mbrw_csc.sv
module mbrw_csc #(
  parameter int COEF_FRAC_BITS = mbrw_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en1,
  input  logic                        en2,
  input  logic [mbrw_pkg::PIX_W-1:0]  luma,
  input  logic [mbrw_pkg::PIX_W-1:0]  chroma_blue,
  input  logic [mbrw_pkg::PIX_W-1:0]  chroma_red,
  output logic [mbrw_pkg::RGB_W-1:0]  rgb
);
  import mbrw_pkg::*;

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;          // coefficients stay below 2.0
  localparam int PW = F + 13;         // products and sums, signed

  localparam logic signed [CW:0] K_CR_R =
    (CW+1)'(((64'd1402 << F) + 64'd500) / 64'd1000);
  localparam logic signed [CW:0] K_CB_G =
    (CW+1)'(((64'd34414 << F) + 64'd50000) / 64'd100000);
  localparam logic signed [CW:0] K_CR_G =
    (CW+1)'(((64'd71414 << F) + 64'd50000) / 64'd100000);
  localparam logic signed [CW:0] K_CB_B =
    (CW+1)'(((64'd1772 << F) + 64'd500) / 64'd1000);

  localparam logic signed [PIX_W+1:0] C_OFS = 10'sd128;

  function automatic logic [PIX_W-1:0] clamp(input logic signed [PW-1:0] v);
    logic [PW-F-1:0] sh;
    sh = v[PW-1:F];
    if (v < 0) begin
      clamp = '0;
    end else if (|sh[PW-F-1:PIX_W]) begin
      clamp = '1;
    end else begin
      clamp = sh[PIX_W-1:0];
    end
  endfunction

  logic signed [PIX_W+1:0] cb_s;
  logic signed [PIX_W+1:0] cr_s;
  logic signed [PW-1:0]    base;
  logic signed [PW-1:0]    p_rr;
  logic signed [PW-1:0]    p_gb;
  logic signed [PW-1:0]    p_gr;
  logic signed [PW-1:0]    p_bb;
  logic signed [PW-1:0]    sum_r;
  logic signed [PW-1:0]    sum_g;
  logic signed [PW-1:0]    sum_b;

  assign cb_s = $signed({2'b00, chroma_blue}) - C_OFS;
  assign cr_s = $signed({2'b00, chroma_red}) - C_OFS;

  // Products with the constant coefficients
  always_ff @(posedge clk) begin
    if (en1) begin
      base <= $signed({{(PW-PIX_W-F){1'b0}}, luma, {F{1'b0}}});
      p_rr <= K_CR_R * cr_s;
      p_gb <= K_CB_G * cb_s;
      p_gr <= K_CR_G * cr_s;
      p_bb <= K_CB_B * cb_s;
    end
  end

  assign sum_r = base + p_rr;
  assign sum_g = base - p_gb - p_gr;
  assign sum_b = base + p_bb;

  // Clamp and pack B, G, R from the top byte down
  always_ff @(posedge clk) begin
    if (en2) begin
      rgb <= {clamp(sum_b), clamp(sum_g), clamp(sum_r)};
    end
  end

endmodule

>>> design/mbrw_div.sv
module mbrw_div (
  input  logic                         clk,
  input  logic [mbrw_pkg::ADDR_W-1:0]  en,
  input  logic [mbrw_pkg::ADDR_W-1:0]  num,
  input  logic [mbrw_pkg::PR_W-1:0]    den,
  input  mbrw_pkg::mbrw_side_t         side_in,
  output logic [mbrw_pkg::ADDR_W-1:0]  quo,
  output logic [mbrw_pkg::PR_W-1:0]    rem,
  output mbrw_pkg::mbrw_side_t         side_out
);
  import mbrw_pkg::*;

  localparam int NW = ADDR_W;

  logic [PR_W-1:0] rem_q  [NW];
  logic [NW-1:0]   num_q  [NW];
  mbrw_side_t      side_q [NW];

  // One restoring step per stage, dividend bits enter MSB first
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [PR_W-1:0] r_prev;
    logic [NW-1:0]   n_prev;
    mbrw_side_t      s_prev;
    logic [PR_W:0]   t;
    logic            ge;

    if (k == 0) begin : g_first
      assign r_prev = '0;
      assign n_prev = num;
      assign s_prev = side_in;
    end else begin : g_next
      assign r_prev = rem_q[k-1];
      assign n_prev = num_q[k-1];
      assign s_prev = side_q[k-1];
    end

    assign t  = {r_prev, n_prev[NW-1]};
    assign ge = (t >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k]  <= ge ? PR_W'(t - {1'b0, den}) : t[PR_W-1:0];
        num_q[k]  <= {n_prev[NW-2:0], ge};
        side_q[k] <= s_prev;
      end
    end
  end

  assign quo      = num_q[NW-1];
  assign rem      = rem_q[NW-1];
  assign side_out = side_q[NW-1];

endmodule

>>> design/macroblock_ycbcr_to_rgb_writer_top.sv
// Throughput: one pixel per cycle while the receiver takes results; the depth
//   is set by the 16-stage address divider (one quotient bit per stage).
// Reset (rst, synchronous, active high) empties the pipeline and loads the
//   frame registers with 720 x 480, 45 macroblocks per row, 1350 macroblocks.
module macroblock_ycbcr_to_rgb_writer_top #(
  parameter int COEF_FRAC_BITS = mbrw_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  mbrw_pkg::cfg_idx_t               cfg_index,
  input  logic [mbrw_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel requests in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] mb_address, [19:16] pixel_col, [23:20] pixel_row,
  // [31:24] luma, [39:32] chroma_blue, [47:40] chroma_red
  input  logic [mbrw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] intra_picture
  input  logic                             s_axis_tuser,
  // frame write requests out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [23:0] pixel_addr, [47:24] rgb_word
  output logic [mbrw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] write_enable
  output logic                             m_axis_tuser,
  // picture_done
  output logic                             m_axis_tlast
);
  import mbrw_pkg::*;

  // Stage map:
  //   0        input capture
  //   1..2     colour conversion (products, then clamp and pack)
  //   3..18    address / macroblocks-per-row, one quotient bit per stage
  //   19       frame position, clipping
  //   20       row stride multiply
  //   21       address add, output register
  localparam int NW = ADDR_W;
  localparam int S_DIV = 3;
  localparam int S_POS = S_DIV + NW;
  localparam int S_MUL = S_POS + 1;
  localparam int S_OUT = S_MUL + 1;
  localparam int NS = S_OUT + 1;

  localparam int PX_W = PR_W + POS_W;
  localparam int PY_W = ADDR_W + POS_W;
  localparam int PROD_W = PY_W + FW_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [FW_W-1:0]  frame_width;
  logic [FW_W-1:0]  frame_height;
  logic [PR_W-1:0]  mbs_per_row;
  logic [MBC_W-1:0] mb_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      mbs_per_row  <= MBS_PER_ROW_RST;
      mb_count     <= MB_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FW_W-1:0];
        CFG_MBS_PER_ROW:  mbs_per_row  <= cfg_data[PR_W-1:0];
        CFG_MB_COUNT:     mb_count     <= cfg_data[MBC_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero row count divides as one; a zero picture count wraps to the
  // highest address.
  logic [PR_W-1:0]   per_row;
  logic [ADDR_W-1:0] last_addr;

  assign per_row   = (mbs_per_row == '0) ? PR_W'(1) : mbs_per_row;
  assign last_addr = mb_count - MBC_W'(1);

  // ---------------------------------------------------------------------
  // Flow control
  // A stage advances when it or any stage after it holds a bubble, or the
  // result is being taken, so gaps close up behind a stalled output.
  // ---------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = m_axis_tready || !(&v[NS-1:i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[NS-1];

  // ---------------------------------------------------------------------
  // Stage 0: capture the request
  // ---------------------------------------------------------------------
  logic              intra0;
  logic [ADDR_W-1:0] addr0;
  logic [POS_W-1:0]  col0;
  logic [POS_W-1:0]  row0;
  logic [PIX_W-1:0]  y0;
  logic [PIX_W-1:0]  cb0;
  logic [PIX_W-1:0]  cr0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      intra0 <= s_axis_tuser;
      addr0  <= s_axis_tdata[15:0];
      col0   <= s_axis_tdata[19:16];
      row0   <= s_axis_tdata[23:20];
      y0     <= s_axis_tdata[31:24];
      cb0    <= s_axis_tdata[39:32];
      cr0    <= s_axis_tdata[47:40];
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1..2: colour conversion runs in its own unit; the position and
  // the end-of-picture test travel beside it.
  // ---------------------------------------------------------------------
  logic              intra1, intra2;
  logic              done1, done2;
  logic [ADDR_W-1:0] addr1, addr2;
  logic [POS_W-1:0]  col1, col2;
  logic [POS_W-1:0]  row1, row2;
  logic [RGB_W-1:0]  rgb2;

  // Picture done follows address, position and intra flag alone,
  // clipping has no say in it.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      intra1 <= intra0;
      addr1  <= addr0;
      col1   <= col0;
      row1   <= row0;
      done1  <= intra0 && (addr0 == last_addr) &&
                (col0 == MB_LAST_POS) && (row0 == MB_LAST_POS);
    end
    if (en[2]) begin
      intra2 <= intra1;
      addr2  <= addr1;
      col2   <= col1;
      row2   <= row1;
      done2  <= done1;
    end
  end

  mbrw_csc #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_csc (
    .clk         (clk),
    .en1         (en[1]),
    .en2         (en[2]),
    .luma        (y0),
    .chroma_blue (cb0),
    .chroma_red  (cr0),
    .rgb         (rgb2)
  );

  // ---------------------------------------------------------------------
  // Stages 3..18: macroblock column and row from the raster address
  // ---------------------------------------------------------------------
  mbrw_side_t        side_div_in;
  mbrw_side_t        side_div;
  logic [ADDR_W-1:0] mb_y;
  logic [PR_W-1:0]   mb_x;

  assign side_div_in = '{intra: intra2, done: done2, col: col2, row: row2, rgb: rgb2};

  mbrw_div u_div (
    .clk      (clk),
    .en       (en[S_DIV +: NW]),
    .num      (addr2),
    .den      (per_row),
    .side_in  (side_div_in),
    .quo      (mb_y),
    .rem      (mb_x),
    .side_out (side_div)
  );

  // ---------------------------------------------------------------------
  // Stage 19: pixel position (a macroblock is 16 wide, so the offset
  // inside it fills the low bits) and clipping against the frame.
  // ---------------------------------------------------------------------
  logic [PX_W-1:0]  px;
  logic [PY_W-1:0]  py;
  logic [PX_W-1:0]  px_p;
  logic [PY_W-1:0]  py_p;
  logic             we_p;
  logic             done_p;
  logic [RGB_W-1:0] rgb_p;

  assign px = {mb_x, side_div.col};
  assign py = {mb_y, side_div.row};

  always_ff @(posedge clk) begin
    if (en[S_POS]) begin
      px_p   <= px;
      py_p   <= py;
      we_p   <= side_div.intra &&
                (px < PX_W'(frame_width)) && (py < PY_W'(frame_height));
      done_p <= side_div.done;
      rgb_p  <= side_div.rgb;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 20: row stride
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] prod_m;
  logic [PX_W-1:0]   px_m;
  logic              we_m;
  logic              done_m;
  logic [RGB_W-1:0]  rgb_m;

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      prod_m <= py_p * frame_width;
      px_m   <= px_p;
      we_m   <= we_p;
      done_m <= done_p;
      rgb_m  <= rgb_p;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 21: output register; drop address and colour when not written
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0]     addr_sum;
  logic [OUT_ADDR_W-1:0] pixel_addr_o;
  logic [RGB_W-1:0]      rgb_o;
  logic                  we_o;
  logic                  done_o;

  assign addr_sum = prod_m + PROD_W'(px_m);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      pixel_addr_o <= we_m ? addr_sum[OUT_ADDR_W-1:0] : '0;
      rgb_o        <= we_m ? rgb_m : '0;
      we_o         <= we_m;
      done_o       <= done_m;
    end
  end

  assign m_axis_tdata = {rgb_o, pixel_addr_o};
  assign m_axis_tuser = we_o;
  assign m_axis_tlast = done_o;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
`include "macroblock_ycbcr_to_rgb_writer_top_assert.svh"

  `MBRW_ASSERT_NOW(a_unwritten_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "pixel not written but payload non-zero")
  `MBRW_ASSERT_NOW(a_bubble_ready, !(&v), s_axis_tready, "pipeline has a bubble but refuses a request")
  `MBRW_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, v[0], "accepted request missing from first stage")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mbrw_pkg::*;

  // Fixed-point colour coefficients, scaled by 2^FRAC and rounded to nearest
  localparam int     FRAC   = COEF_FRAC_BITS_DEF;
  localparam longint K_CR_R = ((longint'(1402) << FRAC) + 500) / 1000;
  localparam longint K_CB_G = ((longint'(34414) << FRAC) + 50000) / 100000;
  localparam longint K_CR_G = ((longint'(71414) << FRAC) + 50000) / 100000;
  localparam longint K_CB_B = ((longint'(1772) << FRAC) + 500) / 1000;

  localparam int PROBE_ROWS   = 20;
  localparam int PHASES       = 9;
  localparam int PHASE_PIXELS = 142;
  localparam int SETTLE       = 30;    // settling wait after the last expected write
  localparam int HOLD_CYCLES  = 400;   // long receiver back-pressure stretch
  localparam int QUIET_LIMIT  = 3000;  // cycles with no request moving on either side

  typedef struct packed {
    logic             intra;
    logic [15:0]      addr;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       y;
    logic [7:0]       cb;
    logic [7:0]       cr;
  } pixel_req_t;

  typedef struct packed {
    logic        we;
    logic [23:0] paddr;
    logic [23:0] rgb;
    logic        done;
  } frame_write_t;

  typedef struct packed {
    logic [FW_W-1:0]  fw;
    logic [FW_W-1:0]  fh;
    logic [PR_W-1:0]  mbs;
    logic [MBC_W-1:0] mbc;
  } frame_regs_t;

  // typed = 1: the expected write is given in the row, else it is predicted
  typedef struct packed {
    pixel_req_t   px;
    logic         typed;
    frame_write_t want;
  } probe_row_t;

  localparam frame_write_t NO_WRITE = '0;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  cfg_idx_t                cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [15:0] mb_address, [19:16] pixel_col, [23:20] pixel_row,
  // [31:24] luma, [39:32] chroma_blue, [47:40] chroma_red
  logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
  // [0] intra_picture
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [23:0] pixel_addr, [47:24] rgb_word
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  // [0] write_enable
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  frame_regs_t  frame_regs;
  frame_write_t writes_due [$];
  int           mismatches = 0;
  int           send_idle_pct = 10;
  int           recv_idle_pct = 49;
  int           holds_asked = 0;
  int           holds_served = 0;
  int           stall_left = 0;
  int unsigned  quiet_cycles = 0;

  // Directed requests, all under the reset frame settings (720x480, 45 per row, 1350)
  probe_row_t probe_table [PROBE_ROWS] = '{
    // black at the frame origin
    '{'{1'b1, 16'd0,    4'd0,  4'd0,  8'd0,   8'd128, 8'd128}, 1'b1,
      '{1'b1, 24'd0, 24'h000000, 1'b0}},
    // white at the far corner of the first macroblock
    '{'{1'b1, 16'd0,    4'd15, 4'd15, 8'd255, 8'd128, 8'd128}, 1'b1,
      '{1'b1, 24'd10815, 24'hFFFFFF, 1'b0}},
    // last pixel of the last macroblock: picture done, bottom-right of the frame
    '{'{1'b1, 16'd1349, 4'd15, 4'd15, 8'd128, 8'd128, 8'd128}, 1'b1,
      '{1'b1, 24'd345599, 24'h808080, 1'b1}},
    // same pixel from a non-intra picture: nothing written, no picture done
    '{'{1'b0, 16'd1349, 4'd15, 4'd15, 8'd128, 8'd128, 8'd128}, 1'b1, NO_WRITE},
    // last macroblock, one short of the last pixel in each direction
    '{'{1'b1, 16'd1349, 4'd14, 4'd15, 8'd77,  8'd200, 8'd33},  1'b0, NO_WRITE},
    '{'{1'b1, 16'd1349, 4'd15, 4'd14, 8'd190, 8'd45,  8'd210}, 1'b0, NO_WRITE},
    // first macroblock below the frame, and the highest address
    '{'{1'b1, 16'd1350, 4'd0,  4'd0,  8'd90,  8'd10,  8'd250}, 1'b1, NO_WRITE},
    '{'{1'b1, 16'hFFFF, 4'd15, 4'd15, 8'd255, 8'd255, 8'd255}, 1'b1, NO_WRITE},
    // right and bottom edges of the frame
    '{'{1'b1, 16'd44,   4'd15, 4'd0,  8'd60,  8'd170, 8'd85},  1'b0, NO_WRITE},
    '{'{1'b1, 16'd1305, 4'd0,  4'd15, 8'd170, 8'd85,  8'd60},  1'b0, NO_WRITE},
    // colour extremes: negative sums, saturation, mixed signs
    '{'{1'b1, 16'd2,    4'd1,  4'd2,  8'd0,   8'd0,   8'd0},   1'b0, NO_WRITE},
    '{'{1'b1, 16'd3,    4'd3,  4'd4,  8'd255, 8'd255, 8'd255}, 1'b0, NO_WRITE},
    '{'{1'b1, 16'd4,    4'd5,  4'd6,  8'd0,   8'd255, 8'd255}, 1'b0, NO_WRITE},
    '{'{1'b1, 16'd5,    4'd7,  4'd8,  8'd255, 8'd0,   8'd0},   1'b0, NO_WRITE},
    '{'{1'b1, 16'd6,    4'd9,  4'd10, 8'd128, 8'd0,   8'd255}, 1'b0, NO_WRITE},
    '{'{1'b1, 16'd7,    4'd11, 4'd12, 8'd128, 8'd255, 8'd0},   1'b0, NO_WRITE},
    // plain grey with neutral chroma, then a strong colour inside the frame
    '{'{1'b1, 16'd1,    4'd3,  4'd2,  8'd16,  8'd128, 8'd128}, 1'b1,
      '{1'b1, 24'd1459, 24'h101010, 1'b0}},
    '{'{1'b1, 16'd600,  4'd13, 4'd14, 8'd235, 8'd16,  8'd240}, 1'b0, NO_WRITE},
    // non-intra inside the frame, then the first pixel of the last macroblock
    '{'{1'b0, 16'd100,  4'd7,  4'd9,  8'd99,  8'd150, 8'd20},  1'b1, NO_WRITE},
    '{'{1'b1, 16'd1349, 4'd0,  4'd0,  8'd15,  8'd240, 8'd127}, 1'b0, NO_WRITE}
  };

  macroblock_ycbcr_to_rgb_writer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Truncate the fraction and clamp one colour channel to a byte
  function automatic logic [7:0] channel_byte(longint v);
    if (v < 0) return 8'd0;
    if ((v >>> FRAC) > 255) return 8'd255;
    return v[FRAC +: 8];
  endfunction

  // Work out the frame write that one pixel request should produce
  function automatic frame_write_t predict_write(pixel_req_t p, frame_regs_t c);
    int unsigned  per_row;
    int unsigned  px;
    int unsigned  py;
    logic [15:0]  last_mb;
    longint       base;
    longint       cbd;
    longint       crd;
    frame_write_t w;
    w       = '0;
    per_row = (c.mbs == 0) ? 1 : c.mbs;
    last_mb = c.mbc - 16'd1;
    px      = (p.addr % per_row) * MB_SIZE + p.col;
    py      = (p.addr / per_row) * MB_SIZE + p.row;
    // picture done ignores the frame bounds
    w.done  = p.intra && p.addr == last_mb && p.col == MB_LAST_POS && p.row == MB_LAST_POS;
    if (p.intra && px < c.fw && py < c.fh) begin
      base    = longint'(p.y) <<< FRAC;
      cbd     = longint'(p.cb) - 128;
      crd     = longint'(p.cr) - 128;
      w.we    = 1'b1;
      w.paddr = 24'(px + py * c.fw);
      w.rgb   = {channel_byte(base + K_CB_B * cbd),
                 channel_byte(base - K_CB_G * cbd - K_CR_G * crd),
                 channel_byte(base + K_CR_R * crd)};
    end
    return w;
  endfunction

  // Mostly addresses inside the picture, now and then the last macroblock or any address
  function automatic pixel_req_t random_pixel(frame_regs_t c);
    logic [15:0] last_mb;
    pixel_req_t  p;
    last_mb = c.mbc - 16'd1;
    p.intra = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0:       p.addr = last_mb;
      1:       p.addr = 16'($urandom);
      default: p.addr = 16'($urandom_range(0, last_mb));
    endcase
    p.col = 4'($urandom);
    p.row = 4'($urandom);
    if (p.addr == last_mb && $urandom_range(0, 1) == 1) begin
      p.col = MB_LAST_POS;
      p.row = MB_LAST_POS;
    end
    p.y  = 8'($urandom);
    p.cb = 8'($urandom);
    p.cr = 8'($urandom);
    return p;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one pixel request, hold it until taken, then queue its expected write
  task automatic send_pixel(input pixel_req_t p, input logic typed, input frame_write_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.cr, p.cb, p.y, p.row, p.col, p.addr};
    s_axis_tuser  <= p.intra;
    do @(posedge clk); while (!s_axis_tready);
    writes_due.push_back(typed ? want : predict_write(p, frame_regs));
  endtask

  // Drop valid, let every expected write come back, then let the pipeline settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; the caller lowers the write enable after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  frame_regs.fw  = val[FW_W-1:0];
      CFG_FRAME_HEIGHT: frame_regs.fh  = val[FW_W-1:0];
      CFG_MBS_PER_ROW:  frame_regs.mbs = val[PR_W-1:0];
      CFG_MB_COUNT:     frame_regs.mbc = val[MBC_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (holds_asked != holds_served) begin
      holds_served  <= holds_served + 1;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare every accepted write request with the oldest one expected
  always @(posedge clk) begin
    frame_write_t got;
    frame_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast};
      if (writes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected write request addr=%0d rgb=%06h",
                                got.paddr, got.rgb));
      end else begin
        want = writes_due.pop_front();
        if (got.we !== want.we)
          flag_mismatch($sformatf("write_enable got %b want %b", got.we, want.we));
        if (got.paddr !== want.paddr)
          flag_mismatch($sformatf("pixel_addr got %0d want %0d", got.paddr, want.paddr));
        if (got.rgb !== want.rgb)
          flag_mismatch($sformatf("rgb_word got %06h want %06h", got.rgb, want.rgb));
        if (got.done !== want.done)
          flag_mismatch($sformatf("picture_done got %b want %b", got.done, want.done));
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL macroblock_ycbcr_to_rgb_writer_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] fw_val;
    logic [CFG_DATA_W-1:0] fh_val;
    logic [CFG_DATA_W-1:0] mbs_val;
    logic [CFG_DATA_W-1:0] mbc_val;
    frame_regs = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, MBS_PER_ROW_RST, MB_COUNT_RST};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset settings
    for (int i = 0; i < PROBE_ROWS; i++)
      send_pixel(probe_table[i].px, probe_table[i].typed, probe_table[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Idling: sender light / receiver heavy, then swapped, then none
      if (ph == 3) begin
        send_idle_pct = 49;
        recv_idle_pct <= 10;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      case (ph)
        0:       {fw_val, fh_val, mbs_val, mbc_val} = {16'd720, 16'd480, 16'd45, 16'd1350};
        1:       {fw_val, fh_val, mbs_val, mbc_val} = {16'd4095, 16'd4095, 16'd256, 16'hFFFF};
        2:       {fw_val, fh_val, mbs_val, mbc_val} = {16'd1, 16'd1, 16'd1, 16'd1};
        // zero frame, zero per row (taken as one), zero count (last address wraps)
        3:       {fw_val, fh_val, mbs_val, mbc_val} = '0;
        // all ones: each register keeps only its own width
        4:       {fw_val, fh_val, mbs_val, mbc_val} = '1;
        6:       {fw_val, fh_val, mbs_val, mbc_val} = {16'd176, 16'd144, 16'd11, 16'd99};
        8:       {fw_val, fh_val, mbs_val, mbc_val} = {16'd352, 16'd288, 16'd22, 16'd396};
        default: {fw_val, fh_val, mbs_val, mbc_val} =
                   {16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                    16'($urandom_range(1, 256)), 16'($urandom_range(1, 65535))};
      endcase
      drain();
      write_reg(CFG_FRAME_WIDTH, fw_val);
      write_reg(CFG_FRAME_HEIGHT, fh_val);
      write_reg(CFG_MBS_PER_ROW, mbs_val);
      write_reg(CFG_MB_COUNT, mbc_val);
      cfg_we <= 1'b0;
      // Hold the receiver off while requests keep coming, so the input backs up
      if (ph == 6) holds_asked <= holds_asked + 1;
      repeat (PHASE_PIXELS) send_pixel(random_pixel(frame_regs), 1'b0, NO_WRITE);
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS macroblock_ycbcr_to_rgb_writer_top");
    end else begin
      $display("FAIL macroblock_ycbcr_to_rgb_writer_top");
    end
    $finish;
  end

endmodule
